[design/dq_pkg.sv]
`default_nettype none

package dq_pkg;

   // Action codes carried in the action field of a request.
   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_PEEK_FRONT = 3'd4,
      ACT_PEEK_BACK  = 3'd5,
      ACT_FIND       = 3'd6,
      ACT_REMOVE     = 3'd7
   } action_type;

   // Status codes carried in a response.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Source of the data word in a response.
   typedef enum logic [1:0] {
      DSEL_ZERO = 2'd0,
      DSEL_READ = 2'd1,
      DSEL_KEY  = 2'd2
   } dsel_type;

   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 5;

   typedef struct packed {
      action_type            action;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] data_out;
      logic                  ok;
      status_type            status;
      logic [COUNT_BITS-1:0] item_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      logic       push_front;
      logic       push_back;
      logic       rd_front;
      logic       rd_back;
      logic       front_inc;
      logic       count_dec;
      logic       scan_init;
      logic       shift_init;
      logic       walk;
      logic       walk_write;
      logic       finish;
      status_type status;
      dsel_type   dsel;
   } dq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       empty;
      logic       full;
      logic       hit;
      logic       drained;
   } dq_stat_type;

endpackage

`default_nettype wire

[design/dq_datapath.sv]
`default_nettype none

module dq_datapath #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  dq_pkg::req_type     req_payload,
   input  dq_pkg::dq_cmd_type  cmd,
   output dq_pkg::dq_stat_type stat,
   output logic                rsp_strobe,
   output dq_pkg::rsp_type     rsp_payload
);
   import dq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] store_mem [DEPTH];

   action_type           action_ff, action_in;
   logic [WORD_BITS-1:0] key_ff, key_in;
   logic [AW-1:0]        front_ff, front_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rd_off_ff, rd_off_in;
   logic [CW-1:0]        cmp_off_ff, cmp_off_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_wa, mem_ra, front_dec;
   logic [WORD_BITS-1:0] mem_wd, word_in;
   logic [VALUE_BITS-1:0] read_word, key_word;
   logic [COUNT_BITS-1:0] count_out;
   logic                 rd_more;

   // Ring position of a word at the given offset from the front.
   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] front,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = {{(CW + 1 - AW){1'b0}}, front} + {1'b0, off};
      if (sum >= (CW + 1)'(DEPTH)) begin
         sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   generate
      if (WORD_BITS <= VALUE_BITS) begin : g_narrow
         assign word_in   = req_payload.value[WORD_BITS-1:0];
         assign read_word = VALUE_BITS'(rd_data_ff);
         assign key_word  = VALUE_BITS'(key_ff);
      end else begin : g_wide
         assign word_in   = {{(WORD_BITS - VALUE_BITS){1'b0}}, req_payload.value};
         assign read_word = rd_data_ff[VALUE_BITS-1:0];
         assign key_word  = key_ff[VALUE_BITS-1:0];
      end
      if (CW >= COUNT_BITS) begin : g_cnt_trunc
         assign count_out = count_in[COUNT_BITS-1:0];
      end else begin : g_cnt_ext
         assign count_out = {{(COUNT_BITS - CW){1'b0}}, count_in};
      end
   endgenerate

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
   assign rd_more   = rd_off_ff < count_ff;

   assign stat.action  = action_ff;
   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == CW'(DEPTH));
   assign stat.hit     = cmp_vld_ff && (rd_data_ff == key_ff);
   assign stat.drained = !rd_more && !cmp_vld_ff;

   always_comb begin
      action_in     = action_ff;
      key_in        = key_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      rd_off_in     = rd_off_ff;
      cmp_off_in    = cmp_off_ff;
      cmp_vld_in    = cmp_vld_ff;
      mem_we        = 1'b0;
      mem_wa        = front_dec;
      mem_wd        = key_ff;
      mem_re        = 1'b0;
      mem_ra        = front_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (cmd.latch) begin
         action_in = req_payload.action;
         key_in    = word_in;
      end
      if (cmd.push_front) begin
         mem_we   = 1'b1;
         mem_wa   = front_dec;
         front_in = front_dec;
         count_in = count_ff + 1'b1;
      end
      if (cmd.push_back) begin
         mem_we   = 1'b1;
         mem_wa   = ring_pos(front_ff, count_ff);
         count_in = count_ff + 1'b1;
      end
      if (cmd.rd_front) begin
         mem_re = 1'b1;
         mem_ra = front_ff;
      end
      if (cmd.rd_back) begin
         mem_re = 1'b1;
         mem_ra = ring_pos(front_ff, count_ff - 1'b1);
      end
      if (cmd.front_inc) begin
         front_in = ring_pos(front_ff, CW'(1));
      end
      if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.scan_init) begin
         rd_off_in  = '0;
         cmp_vld_in = 1'b0;
      end
      if (cmd.shift_init) begin
         rd_off_in  = cmp_off_ff + 1'b1;
         cmp_vld_in = 1'b0;
      end
      if (cmd.walk) begin
         // During a shift, the word read one cycle ago moves one place forward.
         if (cmd.walk_write && cmp_vld_ff) begin
            mem_we = 1'b1;
            mem_wa = ring_pos(front_ff, cmp_off_ff - 1'b1);
            mem_wd = rd_data_ff;
         end
         if (rd_more) begin
            mem_re     = 1'b1;
            mem_ra     = ring_pos(front_ff, rd_off_ff);
            cmp_off_in = rd_off_ff;
            rd_off_in  = rd_off_ff + 1'b1;
            cmp_vld_in = 1'b1;
         end else begin
            cmp_vld_in = 1'b0;
         end
      end
      if (cmd.finish) begin
         rsp_strobe_in     = 1'b1;
         rsp_in.status     = cmd.status;
         rsp_in.ok         = (cmd.status == ST_OK);
         rsp_in.item_count = count_out;
         unique case (cmd.dsel)
            DSEL_READ: rsp_in.data_out = read_word;
            DSEL_KEY:  rsp_in.data_out = key_word;
            default:   rsp_in.data_out = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         rd_off_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         rd_off_ff     <= rd_off_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      key_ff     <= key_in;
      cmp_off_ff <= cmp_off_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy exceeds the ring depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |-> !stat.full)
      else $error("push written into a full ring");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.count_dec || cmd.rd_front || cmd.rd_back) |-> !stat.empty)
      else $error("word taken from an empty ring");

endmodule

`default_nettype wire

[design/dq_ctrl.sv]
`default_nettype none

module dq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type  cmd,
   output logic                busy
);
   import dq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_FETCH = 5'b00100,
      S_SCAN  = 5'b01000,
      S_SHIFT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ST_OK;
      cmd.dsel   = DSEL_ZERO;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.action)
               ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else if (stat.action == ACT_PUSH_FRONT) begin
                     cmd.push_front = 1'b1;
                  end else begin
                     cmd.push_back = 1'b1;
                  end
               end
               ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                  if (stat.empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_EMPTY;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.rd_front = (stat.action == ACT_POP_FRONT) ||
                                    (stat.action == ACT_PEEK_FRONT);
                     cmd.rd_back  = (stat.action == ACT_POP_BACK) ||
                                    (stat.action == ACT_PEEK_BACK);
                     state_in     = S_FETCH;
                  end
               end
               ACT_FIND, ACT_REMOVE: begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
            endcase
         end
         S_FETCH: begin
            cmd.finish    = 1'b1;
            cmd.dsel      = DSEL_READ;
            cmd.front_inc = (stat.action == ACT_POP_FRONT);
            cmd.count_dec = (stat.action == ACT_POP_FRONT) ||
                            (stat.action == ACT_POP_BACK);
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            priority if (stat.hit) begin
               if (stat.action == ACT_REMOVE) begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.dsel   = DSEL_KEY;
                  state_in   = S_IDLE;
               end
            end else if (stat.drained) begin
               cmd.finish = 1'b1;
               cmd.status = ST_NOTFOUND;
               state_in   = S_IDLE;
            end else begin
               cmd.walk = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.drained) begin
               cmd.count_dec = 1'b1;
               cmd.finish    = 1'b1;
               cmd.dsel      = DSEL_KEY;
               state_in      = S_IDLE;
            end else begin
               cmd.walk       = 1'b1;
               cmd.walk_write = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == S_IDLE))
      else $error("controller did not return to idle after a response");

endmodule

`default_nettype wire

[design/deque_with_match_remove.sv]
`default_nettype none

// Bounded double-ended queue of data words held in a ring memory of DEPTH entries.
// A request is transferred at a rising clock edge where start is high and busy is
// low; req_payload carries the action and the value (a word to push or a key).
// Every request produces exactly one response on rsp_payload, shown for a single
// cycle with rsp_strobe high. The receiver cannot hold responses off, and none is
// needed: one request is in flight at a time, so responses never pile up.
// Steps per action, with N stored words and a match at offset p from the front:
//   push, a push into a full queue, pop or peek of an empty queue: answered in
//   the execute state.
//   pop and peek: then a fetch state, for the registered read of the ring memory.
//   find: reads from the front to a match or through all N words (none if empty);
//   one memory read per word, pipelined against the compare.
//   remove match: as find without a match; on a match the N - 1 - p words behind
//   it then move one place forward, one per cycle.
// busy falls in the cycle the response is shown, so the next request may be
// transferred at the edge that ends it; a new request is not taken before the last is answered.
// Reset empties the queue (front position and count go to zero) and returns the
// controller to idle. The ring memory is not cleared; only occupied entries are read.

module deque_with_match_remove #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  dq_pkg::req_type req_payload,
   output logic            rsp_strobe,
   output dq_pkg::rsp_type rsp_payload
);
   import dq_pkg::*;

   dq_cmd_type  cmd;
   dq_stat_type stat;

   // The controller sequences each action; the datapath owns the ring, pointers
   // and response register.
   dq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   dq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Each request passes through the execute state, so responses never touch.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   import dq_pkg::*;

   localparam int RING_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 1750;
   localparam int QUIET_TAIL   = 200;    // last random items are sent without gaps
   localparam int SETTLE_CYCLES = 48;    // covers a full-queue remove match
   localparam int MAX_REPORTS  = 10;

   // Mirror of the deque contents. It predicts the reply to every transferred
   // request and checks the replies in order against those predictions.
   class deque_mirror;
      logic [VALUE_BITS-1:0] ring_words [RING_DEPTH];
      int                    front_pos;
      int                    fill;
      rsp_type               awaited_replies [$];
      int                    failures;
      int                    replies_seen;
      int                    status_seen [4];

      function new();
         front_pos = 0;
         fill      = 0;
         failures  = 0;
         replies_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int ring_slot(int off);
         return (front_pos + off) % RING_DEPTH;
      endfunction

      function logic [VALUE_BITS-1:0] word_at(int off);
         return ring_words[ring_slot(off)];
      endfunction

      // Works out the reply to one transferred request and updates the mirror.
      function void note_request(req_type r);
         rsp_type    e;
         status_type st;
         int         pos;
         e.data_out = '0;
         st = ST_OK;
         case (r.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
               if (fill >= RING_DEPTH) begin
                  st = ST_FULL;
               end else if (r.action == ACT_PUSH_FRONT) begin
                  front_pos = (front_pos + RING_DEPTH - 1) % RING_DEPTH;
                  ring_words[front_pos] = r.value;
                  fill++;
               end else begin
                  ring_words[ring_slot(fill)] = r.value;
                  fill++;
               end
            end
            ACT_POP_FRONT, ACT_PEEK_FRONT: begin
               if (fill == 0) begin
                  st = ST_EMPTY;
               end else begin
                  e.data_out = ring_words[front_pos];
                  if (r.action == ACT_POP_FRONT) begin
                     front_pos = ring_slot(1);
                     fill--;
                  end
               end
            end
            ACT_POP_BACK, ACT_PEEK_BACK: begin
               if (fill == 0) begin
                  st = ST_EMPTY;
               end else begin
                  e.data_out = ring_words[ring_slot(fill - 1)];
                  if (r.action == ACT_POP_BACK) fill--;
               end
            end
            default: begin
               // Find and remove match search from the front towards the back.
               pos = fill;
               for (int i = 0; i < fill; i++) begin
                  if (ring_words[ring_slot(i)] == r.value) begin
                     pos = i;
                     break;
                  end
               end
               if (pos >= fill) begin
                  st = ST_NOTFOUND;
               end else begin
                  e.data_out = ring_words[ring_slot(pos)];
                  if (r.action == ACT_REMOVE) begin
                     for (int i = pos; i + 1 < fill; i++)
                        ring_words[ring_slot(i)] = ring_words[ring_slot(i + 1)];
                     fill--;
                  end
               end
            end
         endcase
         e.ok         = (st == ST_OK);
         e.status     = st;
         e.item_count = fill[COUNT_BITS-1:0];
         awaited_replies.push_back(e);
      endfunction

      function void report(string what, rsp_type e, rsp_type a);
         failures++;
         if (failures <= MAX_REPORTS)
            $display({"%s: expected data %h ok %0d status %0d count %0d, ",
                      "got data %h ok %0d status %0d count %0d"},
                     what, e.data_out, e.ok, e.status, e.item_count,
                     a.data_out, a.ok, a.status, a.item_count);
      endfunction

      // Compares one reply with the oldest prediction, field by field.
      function void check_reply(rsp_type a);
         rsp_type e;
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            e = '0;
            report("reply with no request outstanding", e, a);
            return;
         end
         e = awaited_replies.pop_front();
         status_seen[e.status]++;
         if (a.data_out !== e.data_out || a.ok !== e.ok || a.status !== e.status ||
             a.item_count !== e.item_count)
            report("reply mismatch", e, a);
      endfunction
   endclass

   logic    clock;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   deque_mirror mirror = new();
   int requests_sent = 0;

   logic [VALUE_BITS-1:0] word_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                           32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                                           32'h1234_5678, 32'h7FFF_FFFF};

   deque_with_match_remove #(
      .DEPTH    (RING_DEPTH),
      .WORD_BITS(VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a correct run needs well under a fifth of this time.
   initial begin
      #(12 * 800000);
      $display("tb_top failed");
      $finish;
   end

   // Monitor. Both sides are sampled at the rising edge, before the driver's
   // nonblocking updates land, so the values seen are the ones the block saw.
   // A reply shown in the same cycle as a new transfer belongs to the previous
   // request, so it is checked first.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) mirror.check_reply(rsp_payload);
         if (start && !busy) mirror.note_request(req_payload);
      end
   end

   // Presents one request and returns at the edge where it is transferred.
   // The start line is left high so that a following request can go out
   // back to back without a glitch.
   task automatic send_op(action_type act, logic [VALUE_BITS-1:0] val);
      req_type r;
      r.action = act;
      r.value  = val;
      start       <= 1'b1;
      req_payload <= r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      requests_sent++;
   endtask

   task automatic idle_for(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds the sender off until every predicted reply has come back. The first
   // edge lets the monitor note the last transfer before the count is read.
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.awaited_replies.size() != 0) @(posedge clock);
   endtask

   // Draws an action whose mix depends on the current phase: filling,
   // draining or balanced, so that the queue swings between empty and full.
   function automatic action_type pick_action(int mode);
      int push_w, pop_w, peek_w, r;
      bit back;
      case (mode)
         0:       begin push_w = 55; pop_w = 15; peek_w = 10; end
         1:       begin push_w = 15; pop_w = 50; peek_w = 10; end
         default: begin push_w = 35; pop_w = 30; peek_w = 10; end
      endcase
      r    = $urandom_range(0, 99);
      back = 1'($urandom_range(0, 1));
      if (r < push_w) return back ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      if (r < push_w + pop_w) return back ? ACT_POP_BACK : ACT_POP_FRONT;
      if (r < push_w + pop_w + peek_w) return back ? ACT_PEEK_BACK : ACT_PEEK_FRONT;
      return back ? ACT_REMOVE : ACT_FIND;
   endfunction

   // Pushed words often come from a small pool so that duplicates exist;
   // keys are mostly taken from the stored words so that searches hit.
   function automatic logic [VALUE_BITS-1:0] pick_value(action_type act);
      int held;
      held = mirror.fill;
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if ($urandom_range(0, 9) < 4) return word_pool[$urandom_range(0, 7)];
            return $urandom;
         end
         ACT_FIND, ACT_REMOVE: begin
            if (held > 0 && $urandom_range(0, 9) < 7)
               return mirror.word_at($urandom_range(0, held - 1));
            if ($urandom_range(0, 1)) return word_pool[$urandom_range(0, 7)];
            return $urandom;
         end
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int         mode;
      bit         gaps_on;
      action_type act;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Every end action and every search on an empty queue
      // must report empty or not found and leave the count at zero.
      send_op(ACT_POP_FRONT,  32'h0000_0000);
      send_op(ACT_POP_BACK,   32'hFFFF_FFFF);
      send_op(ACT_PEEK_FRONT, 32'h0000_0000);
      send_op(ACT_PEEK_BACK,  32'hFFFF_FFFF);
      send_op(ACT_FIND,       32'h0000_0000);
      send_op(ACT_REMOVE,     32'hFFFF_FFFF);

      // Fill the ring from both ends with extreme words and a duplicate key,
      // so that the front position wraps below zero.
      for (int i = 0; i < RING_DEPTH; i++) begin
         case (i % 4)
            0: send_op(ACT_PUSH_FRONT, 32'h0000_0000);
            1: send_op(ACT_PUSH_BACK,  32'hFFFF_FFFF);
            2: send_op(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
            default: send_op(ACT_PUSH_BACK, 32'h0000_0100 + i);
         endcase
      end

      // A full queue drops pushed words at either end.
      send_op(ACT_PUSH_FRONT, 32'hDEAD_0001);
      send_op(ACT_PUSH_BACK,  32'hDEAD_0002);
      send_op(ACT_PEEK_FRONT, 32'h0000_0000);
      send_op(ACT_PEEK_BACK,  32'h0000_0000);
      send_op(ACT_FIND,       32'hFFFF_FFFF);
      send_op(ACT_FIND,       32'hDEAD_0001);
      // Removing a duplicated word takes the first one from the front and
      // closes the gap behind it; a missing key leaves everything in place.
      send_op(ACT_REMOVE,     32'h5A5A_5A5A);
      send_op(ACT_REMOVE,     32'hDEAD_0002);
      send_op(ACT_POP_FRONT,  32'h0000_0000);
      send_op(ACT_POP_BACK,   32'h0000_0000);
      wait_for_drain();

      // Random part. Phases change every 150 requests; within a phase gaps
      // are either on or off so that there are stretches of full throughput.
      mode    = 2;
      gaps_on = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            mode    = $urandom_range(0, 2);
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         if (n % 400 == 399) wait_for_drain();
         act = pick_action(mode);
         send_op(act, pick_value(act));
         if (n < RANDOM_ITEMS - QUIET_TAIL && gaps_on && $urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 13));
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mirror.awaited_replies.size() != 0) begin
         mirror.failures++;
         $display("%0d replies never arrived", mirror.awaited_replies.size());
      end
      $display("Sent %0d requests and checked %0d replies, %0d mismatches.",
               requests_sent, mirror.replies_seen, mirror.failures);
      $display("Reply status mix: ok %0d, empty %0d, full %0d, not found %0d.",
               mirror.status_seen[ST_OK], mirror.status_seen[ST_EMPTY],
               mirror.status_seen[ST_FULL], mirror.status_seen[ST_NOTFOUND]);
      if (mirror.failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
design/dq_pkg.sv
design/dq_datapath.sv
design/dq_ctrl.sv
design/deque_with_match_remove.sv
tb/tb_top.sv
